// ----- sv/sfr_pkg.sv -----
package sfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned PAT_W  = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned RIDX_W = 3;

  // Register index, taken from paddr[4:3]
  localparam logic [1:0] REG_FIND_PAT = 2'd0;
  localparam logic [1:0] REG_FIND_LEN = 2'd1;
  localparam logic [1:0] REG_REPL_PAT = 2'd2;
  localparam logic [1:0] REG_REPL_LEN = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_REPL,
    SEL_COUNT
  } out_sel_e;

  typedef struct packed {
    logic     accept;
    logic     emit;
    out_sel_e sel;
    logic     run_last;
    logic     shift;
    logic     match;
    logic     ridx_inc;
    logic     clr_total;
  } sfr_cmd_t;

  typedef struct packed {
    logic pc_zero;
    logic pc_one;
    logic head_ok;
    logic tail_ok;
    logic full;
    logic last;
    logic slot_free;
    logic repl_end;
    logic rlen_zero;
  } sfr_status_t;

endpackage

// ----- sv/sfr_regs.sv -----
module sfr_regs import sfr_pkg::*; #(
  parameter int unsigned MAX_FIND    = 8,
  parameter int unsigned MAX_REPLACE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              pc_zero_i,
  output logic [PAT_W-1:0]  find_pat_o,
  output logic [LEN_W-1:0]  find_len_o,
  output logic [PAT_W-1:0]  repl_pat_o,
  output logic [LEN_W-1:0]  repl_len_o
);

  logic [PAT_W-1:0] find_pat_q, find_pat_d;
  logic [LEN_W-1:0] find_len_q, find_len_d;
  logic [PAT_W-1:0] repl_pat_q, repl_pat_d;
  logic [LEN_W-1:0] repl_len_q, repl_len_d;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic [LEN_W-1:0] wr_len;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];
  assign wr_len  = pwdata[LEN_W-1:0];

  always_comb begin
    find_pat_d = find_pat_q;
    find_len_d = find_len_q;
    repl_pat_d = repl_pat_q;
    repl_len_d = repl_len_q;
    if (wr_en) begin
      case (reg_idx)
        REG_FIND_PAT: find_pat_d = pwdata;
        REG_FIND_LEN: begin
          // ignore while a partial match is held
          if (pc_zero_i) begin
            if (wr_len == '0) begin
              find_len_d = LEN_W'(1);
            end else if (wr_len > LEN_W'(MAX_FIND)) begin
              find_len_d = LEN_W'(MAX_FIND);
            end else begin
              find_len_d = wr_len;
            end
          end
        end
        REG_REPL_PAT: repl_pat_d = pwdata;
        REG_REPL_LEN: begin
          if (wr_len > LEN_W'(MAX_REPLACE)) begin
            repl_len_d = LEN_W'(MAX_REPLACE);
          end else begin
            repl_len_d = wr_len;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_pat_q <= '0;
      find_len_q <= LEN_W'(1);
      repl_pat_q <= '0;
      repl_len_q <= '0;
    end else begin
      find_pat_q <= find_pat_d;
      find_len_q <= find_len_d;
      repl_pat_q <= repl_pat_d;
      repl_len_q <= repl_len_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIND_PAT: prdata = find_pat_q;
      REG_FIND_LEN: prdata = DATA_W'(find_len_q);
      REG_REPL_PAT: prdata = repl_pat_q;
      REG_REPL_LEN: prdata = DATA_W'(repl_len_q);
      default:      prdata = '0;
    endcase
  end

  assign find_pat_o = find_pat_q;
  assign find_len_o = find_len_q;
  assign repl_pat_o = repl_pat_q;
  assign repl_len_o = repl_len_q;

endmodule

// ----- sv/sfr_dp.sv -----
module sfr_dp import sfr_pkg::*; #(
  parameter int unsigned MAX_FIND = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  input  logic [PAT_W-1:0]  find_pat_i,
  input  logic [LEN_W-1:0]  find_len_i,
  input  logic [PAT_W-1:0]  repl_pat_i,
  input  logic [LEN_W-1:0]  repl_len_i,
  input  sfr_cmd_t          cmd_i,
  output sfr_status_t       sts_o,
  output logic              pc_zero_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_byte_valid_o,
  output logic              out_eos_o,
  output logic [CNT_W-1:0]  out_count_o,
  output logic              out_run_last_o
);

  logic [BYTE_W-1:0] win_q [MAX_FIND];
  logic [BYTE_W-1:0] win_d [MAX_FIND];
  logic [LEN_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [LEN_W-1:0]  ridx_q, ridx_d;
  logic              last_q, last_d;
  logic              head_ok, tail_ok;
  logic              slot_free;

  logic              ov_q, ov_d;
  logic [BYTE_W-1:0] ob_q, ob_d;
  logic              obv_q, obv_d;
  logic              oeos_q, oeos_d;
  logic [CNT_W-1:0]  ocnt_q, ocnt_d;
  logic              orl_q, orl_d;

  // prefix compare of the window, and of the window less its oldest byte
  always_comb begin
    head_ok = 1'b1;
    tail_ok = 1'b1;
    for (int i = 0; i < MAX_FIND; i++) begin
      if (LEN_W'(i) < pc_q && win_q[i] != find_pat_i[BYTE_W*i +: BYTE_W]) begin
        head_ok = 1'b0;
      end
    end
    for (int i = 0; i < MAX_FIND - 1; i++) begin
      if (LEN_W'(i + 1) < pc_q && win_q[i+1] != find_pat_i[BYTE_W*i +: BYTE_W]) begin
        tail_ok = 1'b0;
      end
    end
  end

  assign slot_free = !ov_q || out_ready_i;

  always_comb begin
    sts_o.pc_zero   = (pc_q == '0);
    sts_o.pc_one    = (pc_q == LEN_W'(1));
    sts_o.head_ok   = head_ok;
    sts_o.tail_ok   = tail_ok;
    sts_o.full      = (pc_q == find_len_i);
    sts_o.last      = last_q;
    sts_o.slot_free = slot_free;
    sts_o.repl_end  = (ridx_q == repl_len_i - LEN_W'(1));
    sts_o.rlen_zero = (repl_len_i == '0);
  end

  assign pc_zero_o = (pc_q == '0);

  always_comb begin
    win_d   = win_q;
    pc_d    = pc_q;
    total_d = total_q;
    ridx_d  = ridx_q;
    last_d  = last_q;
    if (cmd_i.accept) begin
      for (int i = 0; i < MAX_FIND; i++) begin
        if (pc_q == LEN_W'(i)) begin
          win_d[i] = in_byte_i;
        end
      end
      pc_d   = pc_q + LEN_W'(1);
      last_d = in_last_i;
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < MAX_FIND - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      pc_d = pc_q - LEN_W'(1);
    end
    if (cmd_i.match) begin
      pc_d   = '0;
      ridx_d = '0;
      if (total_q != '1) begin
        total_d = total_q + CNT_W'(1);
      end
    end
    if (cmd_i.ridx_inc) begin
      ridx_d = ridx_q + LEN_W'(1);
    end
    if (cmd_i.clr_total) begin
      total_d = '0;
    end
  end

  // output register
  always_comb begin
    ov_d   = ov_q;
    ob_d   = ob_q;
    obv_d  = obv_q;
    oeos_d = oeos_q;
    ocnt_d = ocnt_q;
    orl_d  = orl_q;
    if (cmd_i.emit) begin
      ov_d  = 1'b1;
      orl_d = cmd_i.run_last;
      case (cmd_i.sel)
        SEL_HEAD: begin
          ob_d = win_q[0]; obv_d = 1'b1; oeos_d = 1'b0; ocnt_d = '0;
        end
        SEL_REPL: begin
          ob_d   = repl_pat_i[{ridx_q[RIDX_W-1:0], 3'b000} +: BYTE_W];
          obv_d  = 1'b1;
          oeos_d = 1'b0;
          ocnt_d = '0;
        end
        SEL_COUNT: begin
          ob_d = '0; obv_d = 1'b0; oeos_d = 1'b1; ocnt_d = total_q;
        end
        default: begin
          ob_d = '0; obv_d = 1'b0; oeos_d = 1'b0; ocnt_d = '0;
        end
      endcase
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      total_q <= '0;
      ridx_q  <= '0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      total_q <= total_d;
      ridx_q  <= ridx_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    ob_q   <= ob_d;
    obv_q  <= obv_d;
    oeos_q <= oeos_d;
    ocnt_q <= ocnt_d;
    orl_q  <= orl_d;
  end

  assign out_valid_o      = ov_q;
  assign out_byte_o       = ob_q;
  assign out_byte_valid_o = obv_q;
  assign out_eos_o        = oeos_q;
  assign out_count_o      = ocnt_q;
  assign out_run_last_o   = orl_q;

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= find_len_i)
    else $error("window holds more bytes than the pattern");

  a_count_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oeos_q |-> orl_q && !obv_q)
    else $error("count result not marked as last text-free result");

  a_total_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_total |=> total_q == '0)
    else $error("match total not cleared after end of stream");

endmodule

// ----- sv/sfr_ctrl.sv -----
module sfr_ctrl import sfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sfr_status_t sts_i,
  output sfr_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = SEL_HEAD;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.pc_zero || (sts_i.head_ok && !sts_i.full)) begin
          state_d = sts_i.last ? ST_FLUSH : ST_IDLE;
        end else if (sts_i.head_ok) begin
          cmd_o.match = 1'b1;
          if (sts_i.rlen_zero) begin
            state_d = sts_i.last ? ST_FLUSH : ST_IDLE;
          end else begin
            state_d = ST_REPL;
          end
        end else if (sts_i.slot_free) begin
          // drop oldest byte; rescan stops if the rest still matches
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_HEAD;
          cmd_o.shift    = 1'b1;
          cmd_o.run_last = !sts_i.last && (sts_i.pc_one || sts_i.tail_ok);
        end
      end
      ST_REPL: begin
        if (sts_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_REPL;
          cmd_o.ridx_inc = 1'b1;
          cmd_o.run_last = sts_i.repl_end && !sts_i.last;
          if (sts_i.repl_end) begin
            state_d = sts_i.last ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pc_zero) begin
            cmd_o.sel       = SEL_COUNT;
            cmd_o.run_last  = 1'b1;
            cmd_o.clr_total = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.sel   = SEL_HEAD;
            cmd_o.shift = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.slot_free)
    else $error("result written into an occupied output register");

endmodule

// ----- sv/stream_find_and_replace.sv -----
// Channel   Dir  Payload                                    Accepted when
// s_axis    in   tdata[7:0] in_byte, tlast in_last          tvalid & tready
// m_axis    out  tdata out_byte/match_count, tuser flags,   tvalid & tready
//                tlast run_last
// apb       in   4 registers at 8*i, 64-bit data            psel & penable & pwrite
//
// Each byte is accepted, then the window is rescanned once per dropped byte
// and closed by a final scan, then the replacement bytes are emitted, and on
// the final byte the window is flushed before the match count is emitted.
// One result leaves per cycle while m_axis is ready, via a single output register.
// Reset clears window count, match total and the output valid.
// A stalled m_axis holds the controller wherever it emits.
module stream_find_and_replace import sfr_pkg::*; #(
  parameter int unsigned MAX_FIND    = 8,
  parameter int unsigned MAX_REPLACE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // [7:0] out_byte, [39:8] match_count
  output logic [1:0]        m_axis_tuser,   // [0] byte_valid, [1] end_of_stream
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [PAT_W-1:0]  find_pat, repl_pat;
  logic [LEN_W-1:0]  find_len, repl_len;
  logic              pc_zero;
  sfr_cmd_t          cmd;
  sfr_status_t       sts;
  logic [BYTE_W-1:0] out_byte;
  logic              out_byte_valid, out_eos;
  logic [CNT_W-1:0]  out_count;

  sfr_regs #(
    .MAX_FIND    (MAX_FIND),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pc_zero_i  (pc_zero),
    .find_pat_o (find_pat),
    .find_len_o (find_len),
    .repl_pat_o (repl_pat),
    .repl_len_o (repl_len)
  );

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_dp #(
    .MAX_FIND (MAX_FIND)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_byte_i        (s_axis_tdata),
    .in_last_i        (s_axis_tlast),
    .find_pat_i       (find_pat),
    .find_len_i       (find_len),
    .repl_pat_i       (repl_pat),
    .repl_len_i       (repl_len),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pc_zero_o        (pc_zero),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (out_byte),
    .out_byte_valid_o (out_byte_valid),
    .out_eos_o        (out_eos),
    .out_count_o      (out_count),
    .out_run_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_byte};
  assign m_axis_tuser = {out_eos, out_byte_valid};

endmodule

// ----- tb/tb_top.sv -----
module tb_top import sfr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FIND_LEN  = 8;
  localparam int unsigned MAX_REPL_LEN  = 8;
  localparam int unsigned MAX_PER_BYTE  = 17;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned WATCHDOG_MAX  = 2000;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_stream;
    logic [31:0] match_count;
    logic        run_last;
  } fr_result_t;

  class fr_scoreboard;
    logic [63:0]  find_pat;
    logic [63:0]  repl_pat;
    int unsigned  find_len;
    int unsigned  repl_len;
    logic [7:0]   window [8];
    int unsigned  window_cnt;
    logic [31:0]  match_total;
    fr_result_t   expected_q[$];
    int unsigned  errors;

    function new();
      find_pat    = '0;
      repl_pat    = '0;
      find_len    = 1;
      repl_len    = 0;
      window_cnt  = 0;
      match_total = '0;
      errors      = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [63:0] value);
      int unsigned len;
      len = 32'(value[3:0]);
      case (idx)
        REG_FIND_PAT: find_pat = value;
        REG_FIND_LEN: begin
          // a length change is dropped while a partial match is held
          if (window_cnt == 0) begin
            if (len == 0) find_len = 1;
            else if (len > MAX_FIND_LEN) find_len = MAX_FIND_LEN;
            else find_len = len;
          end
        end
        REG_REPL_PAT: repl_pat = value;
        REG_REPL_LEN: repl_len = (len > MAX_REPL_LEN) ? MAX_REPL_LEN : len;
        default: ;
      endcase
    endfunction

    function void drop_window(int unsigned n);
      if (n >= window_cnt) begin
        window_cnt = 0;
      end else begin
        for (int i = 0; i + n < window_cnt; i++) window[i] = window[i + n];
        window_cnt -= n;
      end
    endfunction

    static function fr_result_t text_result(logic [7:0] b);
      fr_result_t r;
      r = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      return r;
    endfunction

    function void note_input(logic [7:0] in_byte, logic in_last);
      fr_result_t  run_q[$];
      fr_result_t  r;
      int unsigned n;
      bit          hit;
      if (window_cnt < 8) begin
        window[window_cnt] = in_byte;
        window_cnt++;
      end
      while (window_cnt > 0) begin
        n = (window_cnt < find_len) ? window_cnt : find_len;
        hit = 1'b1;
        for (int i = 0; i < n; i++)
          if (window[i] != find_pat[8*i +: 8]) hit = 1'b0;
        if (hit && window_cnt < find_len) break;
        if (hit) begin
          for (int i = 0; i < repl_len; i++) run_q.push_back(text_result(repl_pat[8*i +: 8]));
          if (match_total != '1) match_total++;
          drop_window(find_len);
        end else begin
          // release the oldest byte and rescan the rest
          run_q.push_back(text_result(window[0]));
          drop_window(1);
        end
      end
      if (in_last) begin
        for (int i = 0; i < window_cnt; i++) run_q.push_back(text_result(window[i]));
        window_cnt = 0;
        r = '0;
        r.end_of_stream = 1'b1;
        r.match_count   = match_total;
        run_q.push_back(r);
        match_total = '0;
      end
      while (run_q.size() > MAX_PER_BYTE) void'(run_q.pop_back());
      if (run_q.size() > 0) begin
        r = run_q.pop_back();
        r.run_last = 1'b1;
        run_q.push_back(r);
      end
      foreach (run_q[j]) expected_q.push_back(run_q[j]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(fr_result_t got);
      fr_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, actual %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      compare_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
      compare_field("end_of_stream", 32'(want.end_of_stream), 32'(got.end_of_stream));
      compare_field("match_count", want.match_count, got.match_count);
      compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [39:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fr_scoreboard sb = new();
  int           send_gap_pct = 0;
  int           stall_pct = 0;
  int           pct_table [3] = '{0, 25, 60};
  int unsigned  idle_cycles = 0;

  stream_find_and_replace DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) < pct)
      return ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    return 0;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [63:0] fp, input logic [3:0] fl,
                             input logic [63:0] rp, input logic [3:0] rl);
    apb_write(REG_FIND_PAT, fp);
    apb_write(REG_FIND_LEN, 64'(fl));
    apb_write(REG_REPL_PAT, rp);
    apb_write(REG_REPL_LEN, 64'(rl));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap(send_gap_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, l);
  endtask

  // drain every pending result, then give a byte with no result time to finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    fr_result_t got;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte      = m_axis_tdata[7:0];
        got.match_count   = m_axis_tdata[39:8];
        got.byte_valid    = m_axis_tuser[0];
        got.end_of_stream = m_axis_tuser[1];
        got.run_last      = m_axis_tlast;
        sb.check_result(got);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap(stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog, no request moved for %0d cycles", $time, idle_cycles);
      $display("stream_find_and_replace test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          ph;
    int          k;
    int          slen;
    int          cnt;
    int          r;
    int          sent;
    int          flen_w;
    int          rlen_w;
    int          eff_flen;
    logic [7:0]  alpha [2];
    logic [63:0] fpat;
    logic [63:0] rpat;
    logic [7:0]  stream_q[$];

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 30;
    stall_pct    = 30;

    // reset settings delete every zero byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    // "aab" with an oversized replacement length
    load_config(64'h0000_0000_0062_6161, 4'd3, 64'h00FF_00FF_5AA5_FF00, 4'd15);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b1);
    settle();

    // hold a partial match across register writes
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    settle();
    apb_write(REG_FIND_LEN, 64'd1);
    apb_write(REG_FIND_PAT, 64'h0000_0000_0063_6161);
    send_byte(8'h63, 1'b0);
    send_byte(8'h78, 1'b1);
    settle();
    send_byte(8'h61, 1'b0);
    settle();
    apb_write(REG_FIND_PAT, 64'h0000_0000_0062_6262);
    send_byte(8'h62, 1'b1);
    settle();

    // zero find length acts as one
    load_config(64'h62, 4'd0, 64'h5A, 4'd1);
    send_byte(8'h62, 1'b0);
    send_byte(8'h71, 1'b1);
    settle();

    // oversized find length, full window match into a full replacement
    load_config('1, 4'd9, 64'h0, 4'd8);
    for (k = 0; k < 8; k++) send_byte(8'hFF, k == 7);
    settle();

    for (ph = 0; ph < 8; ph++) begin
      alpha[0] = 8'($urandom_range(255));
      alpha[1] = 8'($urandom_range(255));
      if (ph == 1) begin
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
      end
      case (ph)
        0: begin flen_w = 1; rlen_w = 8; end
        1: begin flen_w = 8; rlen_w = 0; end
        2: begin flen_w = 0; rlen_w = $urandom_range(15, 9); end
        3: begin flen_w = $urandom_range(15, 9); rlen_w = 1; end
        default: begin flen_w = $urandom_range(8, 1); rlen_w = $urandom_range(8, 0); end
      endcase
      eff_flen = (flen_w == 0) ? 1 : ((flen_w > 8) ? 8 : flen_w);
      for (k = 0; k < 8; k++) begin
        fpat[8*k +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : alpha[$urandom_range(1)];
        rpat[8*k +: 8] = 8'($urandom_range(255));
      end
      load_config(fpat, 4'(flen_w), rpat, 4'(rlen_w));
      send_gap_pct = pct_table[ph % 3];
      stall_pct    = pct_table[(ph / 2) % 3];

      sent = 0;
      while (sent < 36) begin
        stream_q.delete();
        slen = $urandom_range(20, 1);
        while (stream_q.size() < slen) begin
          r = $urandom_range(99);
          if (r < 35) begin
            // pattern copy, sometimes cut short or with a broken tail
            cnt = ($urandom_range(3) == 0) ? $urandom_range(eff_flen, 1) : eff_flen;
            for (k = 0; k < cnt; k++) stream_q.push_back(fpat[8*k +: 8]);
            if ($urandom_range(4) == 0)
              stream_q[stream_q.size() - 1] = alpha[$urandom_range(1)];
          end else if (r < 88) begin
            stream_q.push_back(alpha[$urandom_range(1)]);
          end else begin
            stream_q.push_back(8'($urandom_range(255)));
          end
        end
        foreach (stream_q[j]) send_byte(stream_q[j], j == stream_q.size() - 1);
        sent += stream_q.size();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("stream_find_and_replace test passed");
    end else begin
      $display("stream_find_and_replace test failed");
    end
    $finish;
  end

endmodule
